FILE: rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared constants, codes and controller/datapath interface types for the
// stripe request splitter.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned MaxDisks    = 16;
  localparam int unsigned MaxSegments = 64;

  // fixed field widths
  localparam int unsigned DiskCntW = 5;
  localparam int unsigned ChunkW   = 16;
  localparam int unsigned BlockW   = 32;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DiskIdxW = 4;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // widths that follow from the limits
  localparam int unsigned DiskW  = (MaxDisks > 1) ? $clog2(MaxDisks) : 1;
  localparam int unsigned NdW    = $clog2(MaxDisks + 1);
  localparam int unsigned SpanW  = CountW + 1;
  localparam int unsigned LimW   = ChunkW + $clog2(MaxSegments + 1);

  // shared divider: 32-bit dividend, 16-bit divisor, two quotient bits per cycle
  localparam int unsigned DivW       = BlockW;
  localparam int unsigned DivisorW   = ChunkW;
  localparam int unsigned DivRadixW  = 2;
  localparam int unsigned DivSteps   = DivW / DivRadixW;
  localparam int unsigned DivCntW    = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    CfgDiskCount    = 2'd0,
    CfgChunkBlocks  = 2'd1,
    CfgVolumeBlocks = 2'd2
  } srs_cfg_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk      = 2'd0,
    StatusBadAddr = 2'd1,
    StatusTooLong = 2'd2
  } srs_status_e;

  typedef enum logic {
    DivFirstByChunk = 1'b0,
    DivChunkByDisks = 1'b1
  } srs_div_sel_e;

  typedef struct packed {
    logic         in_load;
    logic         div_start;
    srs_div_sel_e div_sel;
    logic         offs_load;
    logic         base_load;
    logic         seg_step;
    logic         out_load;
    logic         out_single;
    srs_status_e  out_status;
  } srs_cmd_t;

  typedef struct packed {
    logic bad;
    logic empty;
    logic too_long;
    logic div_done;
    logic out_free;
    logic seg_last;
  } srs_sts_t;

endpackage

FILE: rtl/srs_div.sv
// ----------------------------------------------------------------------------
// srs_div
// Iterative unsigned divider, restoring, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module srs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [srs_pkg::DivW-1:0]      dividend_i,
  input  logic [srs_pkg::DivisorW-1:0]  divisor_i,
  output logic                          done_o,
  output logic [srs_pkg::DivW-1:0]      quot_o,
  output logic [srs_pkg::DivisorW-1:0]  rem_o
);
  import srs_pkg::*;

  logic                busy_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [DivW-1:0]     q_q, q_d;
  logic [DivisorW-1:0] r_q, r_d;
  logic [DivisorW-1:0] d_q;

  // remainder stays below the divisor, so one compare-subtract per bit
  always_comb begin
    logic [DivisorW:0] t;
    q_d = q_q;
    r_d = r_q;
    t   = '0;
    for (int i = 0; i < DivRadixW; i++) begin
      t   = {r_d, q_d[DivW-1]};
      q_d = {q_d[DivW-2:0], 1'b0};
      if (t >= {1'b0, d_q}) begin
        t      = t - {1'b0, d_q};
        q_d[0] = 1'b1;
      end
      r_d = t[DivisorW-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == DivCntW'(DivSteps - 1));
  assign quot_o = q_q;
  assign rem_o  = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !start_i) |=> !busy_q)
    else $error("divider still busy after last step");

endmodule

FILE: rtl/srs_datapath.sv
// ----------------------------------------------------------------------------
// srs_datapath
// Volume registers, request registers, division and stripe base, per-segment
// address generation and the result register.
// ----------------------------------------------------------------------------
module srs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          opcode_i,
  input  logic [srs_pkg::BlockW-1:0]    first_block_i,
  input  logic [srs_pkg::CountW-1:0]    block_count_i,
  input  srs_pkg::srs_cmd_t             cmd_i,
  output srs_pkg::srs_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          op_kind_o,
  output logic [srs_pkg::DiskIdxW-1:0]  disk_index_o,
  output logic [srs_pkg::BlockW-1:0]    disk_block_o,
  output logic [srs_pkg::CountW-1:0]    segment_blocks_o,
  output logic [srs_pkg::CountW-1:0]    request_offset_o,
  output logic [srs_pkg::StatusW-1:0]   status_o,
  output logic                          last_o
);
  import srs_pkg::*;

  // volume registers
  logic [DiskCntW-1:0] disk_count_q;
  logic [ChunkW-1:0]   chunk_blocks_q;
  logic [BlockW-1:0]   volume_blocks_q;

  // request and walk registers
  logic                op_q;
  logic [BlockW-1:0]   first_q;
  logic [CountW-1:0]   count_q;
  logic [ChunkW-1:0]   offs_q;
  logic [CountW-1:0]   done_q;
  logic [DiskW-1:0]    disk_q;
  logic [BlockW-1:0]   base_q;

  // result register
  logic                out_valid_q;
  logic                out_op_q;
  logic [DiskIdxW-1:0] out_disk_q;
  logic [BlockW-1:0]   out_block_q;
  logic [CountW-1:0]   out_len_q;
  logic [CountW-1:0]   out_off_q;
  srs_status_e         out_status_q;
  logic                out_last_q;

  logic [NdW-1:0]      nd;
  logic [ChunkW-1:0]   cs;
  logic [BlockW:0]     end_blk;
  logic [SpanW-1:0]    span;
  logic [LimW-1:0]     span_lim;
  logic [DivW-1:0]     div_dividend;
  logic [DivisorW-1:0] div_divisor;
  logic                div_done;
  logic [DivW-1:0]     div_quot;
  logic [DivisorW-1:0] div_rem;
  logic [BlockW+ChunkW-1:0] base_full;
  logic [ChunkW-1:0]   room;
  logic [CountW-1:0]   left;
  logic                seg_last;
  logic [CountW-1:0]   seg_len;
  logic [BlockW-1:0]   seg_blk;
  logic                disk_wrap;

  // disk count clamped to 1..MaxDisks, chunk size at least 1
  always_comb begin
    if (disk_count_q == '0) begin
      nd = NdW'(1);
    end else if (32'(disk_count_q) > MaxDisks) begin
      nd = NdW'(MaxDisks);
    end else begin
      nd = NdW'(disk_count_q);
    end
    cs = (chunk_blocks_q == '0) ? ChunkW'(1) : chunk_blocks_q;
  end

  assign end_blk  = {1'b0, first_q} + (BlockW + 1)'(count_q);
  // more than MaxSegments chunks touched iff offset + count > MaxSegments * chunk
  assign span     = SpanW'(div_rem) + SpanW'(count_q);
  assign span_lim = LimW'(cs) * LimW'(MaxSegments);

  assign div_dividend = (cmd_i.div_sel == DivChunkByDisks) ? div_quot : first_q;
  assign div_divisor  = (cmd_i.div_sel == DivChunkByDisks) ? DivisorW'(nd) : cs;

  srs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign base_full = (BlockW + ChunkW)'(div_quot) * (BlockW + ChunkW)'(cs);

  // current segment
  assign room      = cs - offs_q;
  assign left      = count_q - done_q;
  assign seg_last  = 32'(left) <= 32'(room);
  assign seg_len   = seg_last ? left : CountW'(room);
  assign seg_blk   = base_q + BlockW'(offs_q);
  assign disk_wrap = 32'(disk_q) == (32'(nd) - 32'd1);

  assign sts_o.bad      = end_blk > {1'b0, volume_blocks_q};
  assign sts_o.empty    = count_q == '0;
  assign sts_o.too_long = LimW'(span) > span_lim;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.seg_last = seg_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_count_q    <= DiskCntW'(2);
      chunk_blocks_q  <= ChunkW'(4);
      volume_blocks_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDiskCount:    disk_count_q    <= cfg_data_i[DiskCntW-1:0];
        CfgChunkBlocks:  chunk_blocks_q  <= cfg_data_i[ChunkW-1:0];
        CfgVolumeBlocks: volume_blocks_q <= cfg_data_i[BlockW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q    <= opcode_i;
      first_q <= first_block_i;
      count_q <= block_count_i;
      done_q  <= '0;
    end
    if (cmd_i.offs_load) begin
      offs_q <= div_rem;
    end
    if (cmd_i.base_load) begin
      base_q <= base_full[BlockW-1:0];
      disk_q <= DiskW'(div_rem);
    end
    if (cmd_i.seg_step) begin
      done_q <= done_q + seg_len;
      offs_q <= '0;
      if (disk_wrap) begin
        disk_q <= '0;
        base_q <= base_q + BlockW'(cs);
      end else begin
        disk_q <= disk_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_op_q <= op_q;
      if (cmd_i.out_single) begin
        out_disk_q   <= '0;
        out_block_q  <= '0;
        out_len_q    <= '0;
        out_off_q    <= '0;
        out_status_q <= cmd_i.out_status;
        out_last_q   <= 1'b1;
      end else begin
        out_disk_q   <= DiskIdxW'(disk_q);
        out_block_q  <= seg_blk;
        out_len_q    <= seg_len;
        out_off_q    <= done_q;
        out_status_q <= StatusOk;
        out_last_q   <= seg_last;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign op_kind_o        = out_op_q;
  assign disk_index_o     = out_disk_q;
  assign disk_block_o     = out_block_q;
  assign segment_blocks_o = out_len_q;
  assign request_offset_o = out_off_q;
  assign status_o         = out_status_q;
  assign last_o           = out_last_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  a_seg_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !cmd_i.out_single) |-> (seg_len != '0))
    else $error("empty segment emitted");

  a_disk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seg_step |-> (32'(disk_q) < 32'(nd)))
    else $error("disk index beyond disk count");

endmodule

FILE: rtl/srs_ctrl.sv
// ----------------------------------------------------------------------------
// srs_ctrl
// Request sequencer: range checks, the two divisions, stripe base, then one
// segment per cycle while the result register is free.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srs_pkg::srs_sts_t sts_i,
  output srs_pkg::srs_cmd_t cmd_o
);
  import srs_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StDivChunk,
    StRange,
    StDivDisk,
    StBase,
    StSeg,
    StSingle
  } state_e;

  state_e      state_q, state_d;
  srs_status_e err_q, err_d;

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.div_sel    = DivFirstByChunk;
    cmd_o.out_status = err_q;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        priority if (sts_i.bad) begin
          err_d   = StatusBadAddr;
          state_d = StSingle;
        end else if (sts_i.empty) begin
          err_d   = StatusOk;
          state_d = StSingle;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = StDivChunk;
        end
      end
      StDivChunk: begin
        if (sts_i.div_done) begin
          state_d = StRange;
        end
      end
      StRange: begin
        // quotient is the first chunk, remainder the offset in it
        cmd_o.offs_load = 1'b1;
        if (sts_i.too_long) begin
          err_d   = StatusTooLong;
          state_d = StSingle;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DivChunkByDisks;
          state_d         = StDivDisk;
        end
      end
      StDivDisk: begin
        if (sts_i.div_done) begin
          state_d = StBase;
        end
      end
      StBase: begin
        cmd_o.base_load = 1'b1;
        state_d         = StSeg;
      end
      StSeg: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.seg_step = 1'b1;
          if (sts_i.seg_last) begin
            state_d = StIdle;
          end
        end
      end
      StSingle: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_single = 1'b1;
          state_d          = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      err_q   <= StatusOk;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: rtl/stripe_request_splitter.sv
// ----------------------------------------------------------------------------
// stripe_request_splitter
// Maps a striped-volume read/write request onto per-disk segments, split at
// chunk boundaries, with bad-address and too-long checks.
// ----------------------------------------------------------------------------
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   opcode, first_block, block_count
//   out      out_valid_o / out_ready_i op_kind, disk_index, disk_block,
//                                      segment_blocks, request_offset,
//                                      status, last
//   cfg      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request at a time: check, a radix-4 division, range, a second radix-4
// division and base, then one segment per cycle while the output register is
// free; a bad-address or empty request ends at check, a too-long one at range.
// A stalled output holds the segment walk; the next request is taken once the
// last result sits in the output register.
// Reset gives disk_count 2, chunk_blocks 4, volume_blocks 0.
// ----------------------------------------------------------------------------
module stripe_request_splitter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [srs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [srs_pkg::BlockW-1:0]    first_block_i,
  input  logic [srs_pkg::CountW-1:0]    block_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          op_kind_o,
  output logic [srs_pkg::DiskIdxW-1:0]  disk_index_o,
  output logic [srs_pkg::BlockW-1:0]    disk_block_o,
  output logic [srs_pkg::CountW-1:0]    segment_blocks_o,
  output logic [srs_pkg::CountW-1:0]    request_offset_o,
  output logic [srs_pkg::StatusW-1:0]   status_o,
  output logic                          last_o
);
  import srs_pkg::*;

  srs_cmd_t cmd;
  srs_sts_t sts;

  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srs_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .first_block_i    (first_block_i),
    .block_count_i    (block_count_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .op_kind_o        (op_kind_o),
    .disk_index_o     (disk_index_o),
    .disk_block_o     (disk_block_o),
    .segment_blocks_o (segment_blocks_o),
    .request_offset_o (request_offset_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule

FILE: sim/tb_stripe_request_splitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stripe_request_splitter
// Self-checking bench for the stripe request splitter. A local predictor of the
// raid-0 chunk mapping builds the expected segment stream for every request
// transfer. Directed requests cover the range checks, the empty and over-long
// cases, register extremes and one long receiver hold-off; random traffic then
// runs under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_stripe_request_splitter;
  import srs_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 60;
  localparam logic [BlockW-1:0] BlockMax = '1;

  typedef struct packed {
    logic                op_kind;
    logic [DiskIdxW-1:0] disk_index;
    logic [BlockW-1:0]   disk_block;
    logic [CountW-1:0]   segment_blocks;
    logic [CountW-1:0]   request_offset;
    srs_status_e         status;
    logic                last;
  } segment_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = CfgDiskCount;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                in_valid_i    = 1'b0;
  logic                opcode_i      = 1'b0;
  logic [BlockW-1:0]   first_block_i = '0;
  logic [CountW-1:0]   block_count_i = '0;
  logic                out_ready_i   = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                op_kind_o;
  logic [DiskIdxW-1:0] disk_index_o;
  logic [BlockW-1:0]   disk_block_o;
  logic [CountW-1:0]   segment_blocks_o;
  logic [CountW-1:0]   request_offset_o;
  logic [StatusW-1:0]  status_o;
  logic                last_o;

  // volume geometry as the block holds it
  logic [DiskCntW-1:0] cur_disks  = 5'd2;
  logic [ChunkW-1:0]   cur_chunk  = 16'd4;
  logic [BlockW-1:0]   cur_volume = '0;

  segment_t    expected_segs[$];
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_count = 0;
  int unsigned stalled_cycles = 0;

  stripe_request_splitter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .first_block_i    (first_block_i),
    .block_count_i    (block_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .op_kind_o        (op_kind_o),
    .disk_index_o     (disk_index_o),
    .disk_block_o     (disk_block_o),
    .segment_blocks_o (segment_blocks_o),
    .request_offset_o (request_offset_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // expected segments of one request under the current geometry
  function automatic void split_request(input logic op, input logic [BlockW-1:0] first,
                                        input logic [CountW-1:0] count);
    longint unsigned nd, cs, f, c, offs, chunk, done, len;
    segment_t seg;
    nd = cur_disks;
    cs = cur_chunk;
    f = first;
    c = count;
    if (nd == 0) nd = 1;
    if (nd > MaxDisks) nd = MaxDisks;
    if (cs == 0) cs = 1;
    seg = '0;
    seg.op_kind = op;
    seg.status = StatusOk;
    seg.last = 1'b1;
    // range check runs first, even for empty requests
    if (f + c > cur_volume) begin
      seg.status = StatusBadAddr;
      expected_segs.push_back(seg);
      return;
    end
    if (c == 0) begin
      expected_segs.push_back(seg);
      return;
    end
    offs = f % cs;
    chunk = f / cs;
    if ((offs + c + cs - 1) / cs > MaxSegments) begin
      seg.status = StatusTooLong;
      expected_segs.push_back(seg);
      return;
    end
    done = 0;
    while (done < c) begin
      len = (c - done < cs - offs) ? c - done : cs - offs;
      seg.disk_index = DiskIdxW'(chunk % nd);
      seg.disk_block = BlockW'((chunk / nd) * cs + offs);
      seg.segment_blocks = CountW'(len);
      seg.request_offset = CountW'(done);
      seg.last = (done + len == c);
      expected_segs.push_back(seg);
      done += len;
      chunk++;
      offs = 0;
    end
  endfunction

  function automatic void show_segment(input string tag, input segment_t s);
    $display("  %s op %0d disk %0d blk %h len %0d off %0d status %0d last %0d", tag,
             s.op_kind, s.disk_index, s.disk_block, s.segment_blocks, s.request_offset,
             s.status, s.last);
  endfunction

  task automatic send_request(input logic op, input logic [BlockW-1:0] first,
                              input logic [CountW-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    first_block_i <= first;
    block_count_i <= count;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    split_request(op, first, count);
  endtask

  // registers change only once every segment has drained
  task automatic program_volume(input logic [DiskCntW-1:0] disks,
                                input logic [ChunkW-1:0] chunk,
                                input logic [BlockW-1:0] volume);
    in_valid_i <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgDiskCount;
    cfg_data_i  <= CfgDataW'(disks);
    @(posedge clk_i);
    cur_disks = disks;
    cfg_index_i <= CfgChunkBlocks;
    cfg_data_i  <= CfgDataW'(chunk);
    @(posedge clk_i);
    cur_chunk = chunk;
    cfg_index_i <= CfgVolumeBlocks;
    cfg_data_i  <= CfgDataW'(volume);
    @(posedge clk_i);
    cur_volume = volume;
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_random_geometry();
    logic [DiskCntW-1:0] disks;
    logic [ChunkW-1:0]   chunk;
    logic [BlockW-1:0]   volume;
    case ($urandom_range(7))
      0: disks = '0;
      1: disks = DiskCntW'($urandom_range(31, 17));
      default: disks = DiskCntW'($urandom_range(16, 1));
    endcase
    chunk = ($urandom_range(5) == 0) ? ChunkW'($urandom_range(65535, 0))
                                     : ChunkW'($urandom_range(32, 1));
    case ($urandom_range(2))
      0: volume = BlockMax;
      1: volume = $urandom;
      default: volume = $urandom_range(5000, 0);
    endcase
    program_volume(disks, chunk, volume);
  endtask

  // mostly in-range requests, plus empty, out-of-range, over-long and raw noise
  task automatic send_random_request();
    longint unsigned cs, vol, span, cnt, lo, first;
    int unsigned pick;
    logic op;
    cs = (cur_chunk == 0) ? 1 : cur_chunk;
    vol = cur_volume;
    op = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 65) begin
      span = cs * (($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(6, 1));
      if (span > 65535) span = 65535;
      cnt = $urandom_range(span, 1);
      if (cnt > vol) cnt = vol;
      first = $urandom_range(vol - cnt, 0);
    end else if (pick < 75) begin
      cnt = 0;
      first = $urandom_range(vol, 0);
    end else if (pick < 85) begin
      cnt = $urandom_range(65535, 0);
      lo = (vol + 1 >= cnt) ? vol + 1 - cnt : 0;
      first = (lo > BlockMax) ? $urandom : $urandom_range(BlockMax, lo);
    end else if (pick < 93 && cs < 1024) begin
      cnt = $urandom_range(65535, cs * MaxSegments + 1);
      first = (vol > cnt) ? $urandom_range(vol - cnt, 0) : $urandom;
    end else begin
      cnt = $urandom_range(65535, 0);
      first = $urandom;
    end
    send_request(op, BlockW'(first), CountW'(cnt));
  endtask

  task automatic test_reset_geometry();
    send_request(1'b0, '0, '0);
    send_request(1'b1, '0, 16'd1);
    send_request(1'b0, BlockMax, 16'hFFFF);
  endtask

  task automatic test_chunk_split();
    program_volume(5'd3, 16'd4, 32'd1000);
    send_request(1'b1, 32'd5, 16'd10);
    send_request(1'b0, 32'd0, 16'd256);
    send_request(1'b1, 32'd1, 16'd256);
    send_request(1'b0, 32'd999, 16'd1);
    send_request(1'b1, 32'd999, 16'd2);
    send_request(1'b0, 32'd1000, 16'd0);
    send_request(1'b1, 32'd1001, 16'd0);
    send_request(1'b0, 32'd12, 16'd4);
  endtask

  task automatic test_register_extremes();
    // zero disks and zero chunk size fall back to one
    program_volume(5'd0, 16'd0, BlockMax);
    send_request(1'b1, 32'hFFFF_FFBF, 16'd64);
    send_request(1'b0, BlockMax, 16'd0);
    send_request(1'b1, BlockMax, 16'd1);
    send_request(1'b0, 32'd0, 16'd65);
    program_volume(5'd31, 16'hFFFF, BlockMax);
    send_request(1'b1, 32'hFFFF_0000, 16'hFFFF);
    send_request(1'b0, 32'h7FFF_FFFF, 16'h8000);
    program_volume(5'd17, 16'd1, 32'd100);
    send_request(1'b0, 32'd20, 16'd40);
    program_volume(5'd1, 16'hFFFF, 32'd200000);
    send_request(1'b1, 32'd65530, 16'd10);
    program_volume(5'd16, 16'd7, 32'd500);
    send_request(1'b0, 32'd3, 16'd100);
  endtask

  task automatic test_output_backpressure();
    program_volume(5'd4, 16'd2, BlockMax);
    send_idle_pct = 0;
    sink_stall_pct = 0;
    hold_asked++;
    for (int i = 0; i < 12; i++) begin
      send_request(1'(i), BlockW'(i * 5), CountW'(8 + i));
    end
  endtask

  task automatic run_traffic_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned items);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 30 == 0) program_random_geometry();
      send_random_request();
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(0, 0, 120);
    run_traffic_phase(84, 0, 110);
    run_traffic_phase(0, 84, 110);
    run_traffic_phase(18, 18, 120);
  endtask

  task automatic end_run();
    in_valid_i <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_segs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_chunk_split();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    end_run();
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // outputs are stable mid-cycle, so a transfer seen here completes at the next edge
  always @(negedge clk_i) begin : check_results
    segment_t seen;
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.op_kind        = op_kind_o;
      seen.disk_index     = disk_index_o;
      seen.disk_block     = disk_block_o;
      seen.segment_blocks = segment_blocks_o;
      seen.request_offset = request_offset_o;
      seen.status         = srs_status_e'(status_o);
      seen.last           = last_o;
      if (expected_segs.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected segment at %0t", $realtime);
          show_segment("got", seen);
        end
        mismatch_count++;
      end else begin
        want = expected_segs.pop_front();
        if (seen !== want) begin
          if (mismatch_count < 10) begin
            $display("segment mismatch at %0t", $realtime);
            show_segment("exp", want);
            show_segment("got", seen);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule
